>>> rtl/sct_pkg.sv
`timescale 1ns / 1ps

package sct_pkg;

    localparam int CAPACITY = 128;
    localparam int ID_W     = 29;
    localparam int MS_W     = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPD
    } t_state;

    // broadcast to every cell during the update cycle
    typedef struct packed {
        logic            hit;
        logic            ins;
        logic [ID_W-1:0] key_id;
        logic [MS_W-1:0] now_ms;
    } t_cell_ctl;

    // per-cell compare outcome
    typedef struct packed {
        logic lt;
        logic eq;
        logic first;
    } t_cell_flags;

endpackage

>>> rtl/sct_cell.sv
`timescale 1ns / 1ps

module sct_cell import sct_pkg::*; (
    input  logic            i_clk,
    input  logic            i_valid,
    input  logic            i_load,
    input  logic [ID_W-1:0] i_key_id,
    input  t_cell_ctl       i_ctl,
    input  logic            i_prev_lt,
    input  logic [ID_W-1:0] i_prev_id,
    input  logic [MS_W-1:0] i_prev_seen,
    input  logic [MS_W-1:0] i_prev_dlt,
    output t_cell_flags     o_flags,
    output logic [MS_W-1:0] o_delta_hit,
    output logic [ID_W-1:0] o_id,
    output logic [MS_W-1:0] o_seen,
    output logic [MS_W-1:0] o_dlt
);

    logic [ID_W-1:0] r_id;
    logic [MS_W-1:0] r_seen;
    logic [MS_W-1:0] r_dlt;
    logic            r_lt;
    logic            r_eq;
    logic            w_first;
    logic [MS_W-1:0] w_delta;

    assign w_first = !r_lt && i_prev_lt;
    assign w_delta = i_ctl.now_ms - r_seen;

    // compare against the incoming identifier on accept
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lt <= i_valid && (r_id < i_key_id);
            r_eq <= i_valid && (r_id == i_key_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.hit) begin
            if (r_eq) begin
                r_seen <= i_ctl.now_ms;
                r_dlt  <= w_delta;
            end
        end else if (i_ctl.ins) begin
            if (w_first) begin
                r_id   <= i_ctl.key_id;
                r_seen <= i_ctl.now_ms;
                r_dlt  <= '0;
            end else if (!r_lt) begin
                // above the insertion point: take the neighbor's entry
                r_id   <= i_prev_id;
                r_seen <= i_prev_seen;
                r_dlt  <= i_prev_dlt;
            end
        end
    end

    assign o_flags.lt    = r_lt;
    assign o_flags.eq    = r_eq;
    assign o_flags.first = w_first;
    assign o_delta_hit   = r_eq ? w_delta : '0;
    assign o_id          = r_id;
    assign o_seen        = r_seen;
    assign o_dlt         = r_dlt;

endmodule

>>> rtl/sorted_can_id_tracker.sv
`timescale 1ns / 1ps
// result strobe o_valid is registered from the update state entered at the accepting edge
// busy is high for the single update cycle; no new item is taken until it ends
// the cell row compares on accept, then does one shift/insert/update step
// reset: synchronous active-low i_rst_n empties the table (entry count zero)
// the receiver cannot stall: each result is shown for exactly one cycle

module sorted_can_id_tracker import sct_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [ID_W-1:0] i_can_id,
    input  logic [MS_W-1:0] i_now_ms,
    output logic            o_valid,
    output logic [6:0]      o_position,
    output logic            o_is_new,
    output logic [MS_W-1:0] o_delta_ms,
    output logic            o_dropped,
    output logic [7:0]      o_entry_count
);

    t_state          r_state;
    t_state          n_state;
    logic            w_accept;
    logic            w_upd;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [ID_W-1:0]  r_key_id;
    logic [MS_W-1:0]  r_key_now;

    // chain links: index i feeds cell i, cell i drives index i+1
    logic            w_lt   [0:CAPACITY];
    logic [ID_W-1:0] w_id   [0:CAPACITY];
    logic [MS_W-1:0] w_seen [0:CAPACITY];
    logic [MS_W-1:0] w_dlt  [0:CAPACITY];

    t_cell_flags     w_flags [0:CAPACITY-1];
    logic [MS_W-1:0] w_dhit  [0:CAPACITY-1];
    t_cell_ctl       w_ctl;

    logic            w_hit;
    logic            w_full;
    logic [IDX_W-1:0] w_pos;
    logic [MS_W-1:0] w_delta;

    assign w_accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy  = 1'b0;
        w_upd = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_UPD: begin
                busy  = 1'b1;
                w_upd = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // frame key held for the update cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key_id  <= i_can_id;
            r_key_now <= i_now_ms;
        end
    end

    // head of the chain: everything below cell 0 counts as smaller
    assign w_lt[0]   = 1'b1;
    assign w_id[0]   = '0;
    assign w_seen[0] = '0;
    assign w_dlt[0]  = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic w_valid;
        assign w_valid     = CNT_W'(gi) < r_count;
        assign w_lt[gi+1]  = w_flags[gi].lt;

        sct_cell u_cell (
            .i_clk       (i_clk),
            .i_valid     (w_valid),
            .i_load      (w_accept),
            .i_key_id    (i_can_id),
            .i_ctl       (w_ctl),
            .i_prev_lt   (w_lt[gi]),
            .i_prev_id   (w_id[gi]),
            .i_prev_seen (w_seen[gi]),
            .i_prev_dlt  (w_dlt[gi]),
            .o_flags     (w_flags[gi]),
            .o_delta_hit (w_dhit[gi]),
            .o_id        (w_id[gi+1]),
            .o_seen      (w_seen[gi+1]),
            .o_dlt       (w_dlt[gi+1])
        );
    end

    // or-reduce the one-hot cell outputs: hit flag, lower-bound index, elapsed time
    always_comb begin
        w_hit   = 1'b0;
        w_pos   = '0;
        w_delta = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit   = w_hit | w_flags[i].eq;
            w_pos   = w_pos | (w_flags[i].first ? IDX_W'(i) : '0);
            w_delta = w_delta | w_dhit[i];
        end
    end

    assign w_full       = (r_count == CNT_W'(CAPACITY));
    assign w_ctl.hit    = w_upd && w_hit;
    assign w_ctl.ins    = w_upd && !w_hit && !w_full;
    assign w_ctl.key_id = r_key_id;
    assign w_ctl.now_ms = r_key_now;

    assign n_count = w_ctl.ins ? r_count + CNT_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            o_valid <= w_upd;
        end
    end

    // result registers, loaded in the update cycle
    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            o_position    <= (w_hit || !w_full) ? 7'(w_pos) : '0;
            o_is_new      <= !w_hit && !w_full;
            o_delta_ms    <= w_delta;
            o_dropped     <= !w_hit && w_full;
            o_entry_count <= 8'(n_count);
        end
    end

endmodule

>>> verif/tb_sorted_can_id_tracker.sv
`timescale 1ns / 1ps

module tb_sorted_can_id_tracker;
    import sct_pkg::*;

    // one report of the block, field by field
    typedef struct packed {
        logic [6:0]      position;
        logic            is_new;
        logic [MS_W-1:0] delta_ms;
        logic            dropped;
        logic [7:0]      entry_count;
    } t_frame_report;

    // shadow copy of the sorted id table plus the reports still owed by the block
    class can_id_table_model;
        logic [ID_W-1:0] ids [CAPACITY];
        logic [MS_W-1:0] seen_ms [CAPACITY];
        int unsigned     count = 0;
        t_frame_report   pending[$];
        int unsigned     failures = 0;

        // accepted frame: update the table and queue the report it causes
        function void record_frame(logic [ID_W-1:0] id, logic [MS_W-1:0] ms);
            t_frame_report r;
            int unsigned   slot;
            r = '0;
            slot = 0;
            while (slot < count && ids[slot] < id)
                slot++;
            if (slot < count && ids[slot] == id) begin
                r.delta_ms = ms - seen_ms[slot];
                seen_ms[slot] = ms;
                r.position = slot[6:0];
            end else if (count >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                for (int unsigned k = count; k > slot; k--) begin
                    ids[k]     = ids[k-1];
                    seen_ms[k] = seen_ms[k-1];
                end
                ids[slot]     = id;
                seen_ms[slot] = ms;
                count++;
                r.position = slot[6:0];
                r.is_new   = 1'b1;
            end
            r.entry_count = count[7:0];
            pending = {pending, r};
        endfunction

        // block report: compare with the oldest one owed
        function void check_report(t_frame_report got);
            t_frame_report want;
            if (pending.size() == 0) begin
                if (failures < 10)
                    $display("%0t: unexpected report: pos %0d new %0b delta %0d drop %0b cnt %0d",
                             $realtime, got.position, got.is_new, got.delta_ms,
                             got.dropped, got.entry_count);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.position !== want.position || got.is_new !== want.is_new ||
                got.delta_ms !== want.delta_ms || got.dropped !== want.dropped ||
                got.entry_count !== want.entry_count) begin
                if (failures < 10) begin
                    $display("%0t: expected pos %0d new %0b delta %0d drop %0b cnt %0d",
                             $realtime, want.position, want.is_new, want.delta_ms,
                             want.dropped, want.entry_count);
                    $display("%0t: actual   pos %0d new %0b delta %0d drop %0b cnt %0d",
                             $realtime, got.position, got.is_new, got.delta_ms,
                             got.dropped, got.entry_count);
                end
                failures++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [ID_W-1:0] i_can_id;
    logic [MS_W-1:0] i_now_ms;
    logic            o_valid;
    logic [6:0]      o_position;
    logic            o_is_new;
    logic [MS_W-1:0] o_delta_ms;
    logic            o_dropped;
    logic [7:0]      o_entry_count;

    can_id_table_model model = new;

    // random gaps between items, switched off for one long stretch
    bit idle_en;

    sorted_can_id_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_can_id      (i_can_id),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .o_position    (o_position),
        .o_is_new      (o_is_new),
        .o_delta_ms    (o_delta_ms),
        .o_dropped     (o_dropped),
        .o_entry_count (o_entry_count)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // monitor: outputs and the handshake are sampled on the rising edge
    always @(posedge i_clk) begin
        t_frame_report got;
        if (i_rst_n) begin
            if (o_valid) begin
                got.position    = o_position;
                got.is_new      = o_is_new;
                got.delta_ms    = o_delta_ms;
                got.dropped     = o_dropped;
                got.entry_count = o_entry_count;
                model.check_report(got);
            end
            // item taken when start is seen with busy low
            if (start && !busy)
                model.record_frame(i_can_id, i_now_ms);
        end
    end

    // present one item from a falling edge and hold it until it is taken;
    // returns on the falling edge after acceptance
    task automatic issue_frame(input logic [ID_W-1:0] id, input logic [MS_W-1:0] ms);
        while (idle_en && $urandom_range(99) < 31) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_can_id <= id;
        i_now_ms <= ms;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        logic [ID_W-1:0] id;
        logic [MS_W-1:0] ms_clock;
        int unsigned     sel;
        int unsigned     pick;

        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_can_id = '0;
        i_now_ms = '0;
        idle_en  = 1'b1;
        ms_clock = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, then front, back and middle inserts
        issue_frame(29'h0000_1000, 32'd100);
        issue_frame(29'h0000_1000, 32'd150);
        issue_frame(29'h0000_0000, 32'd0);
        issue_frame(29'h1FFF_FFFF, 32'hFFFF_FFFF);
        issue_frame(29'h0000_0800, 32'd200);
        // known ids, including elapsed times that wrap past zero
        issue_frame(29'h0000_1000, 32'd10);
        issue_frame(29'h0000_0000, 32'hFFFF_FFFF);
        issue_frame(29'h1FFF_FFFF, 32'd5);
        issue_frame(29'h0000_1000, 32'd10);
        // neighbors one above and one below a stored id
        issue_frame(29'h0000_1001, 32'd300);
        issue_frame(29'h0000_0FFF, 32'd301);
        issue_frame(29'h1FFF_FFFE, 32'h8000_0000);
        issue_frame(29'h0000_0001, 32'h7FFF_FFFF);
        issue_frame(29'h1555_5555, 32'hAAAA_AAAA);
        issue_frame(29'h0AAA_AAAA, 32'h5555_5555);
        issue_frame(29'h0000_0FFF, 32'h0000_0000);
        issue_frame(29'h1555_5555, 32'h5555_5555);

        // random: mostly repeat sightings, some new ids and near neighbors;
        // the table fills part way through and later new ids get dropped
        for (int n = 0; n < 1400; n++) begin
            idle_en = !(n >= 500 && n < 800);
            sel = $urandom_range(99);
            if (model.count > 0 && sel < 70) begin
                pick = $urandom_range(model.count - 1);
                id   = model.ids[pick];
            end else if (model.count > 0 && sel < 85) begin
                pick = $urandom_range(model.count - 1);
                id   = $urandom_range(1) ? model.ids[pick] + 1'b1 : model.ids[pick] - 1'b1;
            end else begin
                id = ID_W'($urandom);
            end
            // time mostly advances a little, sometimes jumps anywhere
            if ($urandom_range(99) < 15)
                ms_clock = $urandom;
            else
                ms_clock = ms_clock + $urandom_range(2000);
            issue_frame(id, ms_clock);
        end
        start <= 1'b0;

        // drain the reports still owed, then wait on for stray reports
        while (model.pending.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        model.failures += model.pending.size();

        if (model.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sct_pkg.sv
rtl/sct_cell.sv
rtl/sorted_can_id_tracker.sv
verif/tb_sorted_can_id_tracker.sv
